@@ src/dds_pkg.sv @@
// Shared types and constants for the discrete distribution sampler.
// No dependencies; every other file in src except dds_ram refers to this package by scoped name.
`timescale 1ns / 1ps

package dds_pkg;

  localparam int unsigned MAX_BINS    = 256;
  localparam int unsigned RANDOM_BITS = 16;

  localparam int unsigned ADDR_W   = $clog2(MAX_BINS);
  localparam int unsigned CNT_W    = $clog2(MAX_BINS + 1);
  localparam int unsigned CUM_W    = 24;
  localparam int unsigned PROD_W   = RANDOM_BITS + CUM_W;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned RAND_W   = 16;
  localparam int unsigned LEN_W    = 9;
  localparam int unsigned BIDX_W   = 8;
  localparam int unsigned PC_W     = 8;
  localparam int unsigned CMP_W    = (LEN_W > CNT_W) ? LEN_W : CNT_W;

  localparam logic [CUM_W-1:0] CUM_MAX = '1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_LOCAL  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_NEG   = 3'd2,
    ST_WIN   = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SAMPLE,
    S_LOCAL,
    S_FLUSH
  } state_e;

  typedef struct packed {
    op_e                         op;
    logic signed [WEIGHT_W-1:0]  weight;
    logic                        first;
    logic [RAND_W-1:0]           random_value;
    logic [LEN_W-1:0]            window_length;
  } in_beat_t;

  typedef struct packed {
    status_e           status;
    logic [BIDX_W-1:0] bin_index;
    logic [CUM_W-1:0]  window_sum;
  } out_beat_t;

  typedef struct packed {
    logic en;
    logic [ADDR_W-1:0] addr;
    logic [CUM_W-1:0]  data;
  } ram_wr_t;

  typedef struct packed {
    logic load_lhs;
    logic lo_zero;
  } cmp_ctl_t;

  typedef struct packed {
    logic             hit;
    logic             better;
    logic [CUM_W-1:0] win_sum;
  } eval_t;

endpackage

@@ src/dds_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module dds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/dds_cmp.sv @@
// Compare datapath: scaled draw register, sample threshold test, window sum and best-window test.
// Depends on dds_pkg.
`timescale 1ns / 1ps

module dds_cmp (
  input  logic                         clk_i,
  input  dds_pkg::cmp_ctl_t            ctl_i,
  input  logic [dds_pkg::RAND_W-1:0]   random_i,
  input  logic [dds_pkg::CUM_W-1:0]    total_i,
  input  logic [dds_pkg::CUM_W-1:0]    rd_hi_i,
  input  logic [dds_pkg::CUM_W-1:0]    rd_lo_i,
  input  logic [dds_pkg::CUM_W-1:0]    best_sum_i,
  output dds_pkg::eval_t               eval_o
);

  localparam int unsigned RB = dds_pkg::RANDOM_BITS;
  localparam int unsigned PW = dds_pkg::PROD_W;
  localparam int unsigned CW = dds_pkg::CUM_W;

  logic [RB-1:0] draw;
  logic [PW-1:0] lhs_d, lhs_q;
  logic [PW-1:0] rhs;
  logic [CW-1:0] lo_val;

  // Draw bits above the configured width are dropped.
  assign draw  = RB'(random_i);
  assign lhs_d = PW'(draw) * PW'(total_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_lhs) begin
      lhs_q <= lhs_d;
    end
  end

  // cum * (2^RB - 1) as a shift and a subtract.
  assign rhs    = (PW'(rd_hi_i) << RB) - PW'(rd_hi_i);
  assign lo_val = ctl_i.lo_zero ? '0 : rd_lo_i;

  always_comb begin
    eval_o.hit     = (lhs_q <= rhs);
    eval_o.win_sum = rd_hi_i - lo_val;
    eval_o.better  = (eval_o.win_sum >= best_sum_i);
  end

endmodule

@@ src/dds_ctrl.sv @@
// Sequencer: handshakes, table bookkeeping, load arithmetic and the table scans.
// Depends on dds_pkg; drives the two table RAM copies and the compare datapath.
`timescale 1ns / 1ps

module dds_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dds_pkg::in_beat_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dds_pkg::out_beat_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dds_pkg::PC_W-1:0]       cfg_data_i,
  output dds_pkg::ram_wr_t               wr_o,
  output logic [dds_pkg::ADDR_W-1:0]     rd_hi_addr_o,
  output logic [dds_pkg::ADDR_W-1:0]     rd_lo_addr_o,
  output dds_pkg::cmp_ctl_t              cmp_ctl_o,
  output logic [dds_pkg::CUM_W-1:0]      total_o,
  output logic [dds_pkg::CUM_W-1:0]      best_sum_o,
  input  dds_pkg::eval_t                 eval_i
);

  localparam int unsigned AW = dds_pkg::ADDR_W;
  localparam int unsigned NW = dds_pkg::CNT_W;
  localparam int unsigned CW = dds_pkg::CUM_W;
  localparam int unsigned MW = dds_pkg::CMP_W;
  localparam int unsigned SW = dds_pkg::CUM_W + 1;
  localparam int unsigned BW = dds_pkg::BIDX_W;
  localparam int unsigned WW = dds_pkg::WEIGHT_W;

  dds_pkg::state_e             state_q, state_d;
  logic [NW-1:0]               count_q, count_d;
  logic                        invalid_q, invalid_d;
  logic [CW-1:0]               total_q, total_d;
  logic [dds_pkg::PC_W-1:0]    pc_q, pc_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic [dds_pkg::LEN_W-1:0]   len_q, len_d;
  logic [AW-1:0]               res_idx_q, res_idx_d;
  logic [CW-1:0]               res_sum_q, res_sum_d;
  logic                        out_valid_q, out_valid_d;
  dds_pkg::out_beat_t          out_q, out_d;

  logic          out_free;
  logic          accept;
  logic [NW-1:0] count_eff;
  logic [NW-1:0] cnt_m1;
  logic [CW-1:0] prev;
  logic [SW-1:0] load_sum;
  logic [CW-1:0] load_val;
  logic          full;
  logic          win_bad;
  logic [MW-1:0] len_m1;
  logic [MW-1:0] win_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dds_pkg::S_IDLE;
      count_q     <= '0;
      invalid_q   <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      invalid_q   <= invalid_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q   <= total_d;
    idx_q     <= idx_d;
    len_q     <= len_d;
    res_idx_q <= res_idx_d;
    res_sum_q <= res_sum_d;
    out_q     <= out_d;
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == dds_pkg::S_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Load arithmetic; a restart behaves as an empty table.
  assign count_eff = in_data_i.first ? '0 : count_q;
  assign prev      = (count_eff == '0) ? '0 : total_q;
  assign full      = (count_eff >= NW'(dds_pkg::MAX_BINS));
  assign load_sum  = SW'(prev) + SW'(in_data_i.weight[WW-2:0]) + SW'(pc_q);
  assign load_val  = load_sum[CW] ? dds_pkg::CUM_MAX : load_sum[CW-1:0];

  assign cnt_m1  = count_q - NW'(1);
  assign win_bad = (in_data_i.window_length == '0) ||
                   (MW'(in_data_i.window_length) > MW'(count_q));
  assign len_m1  = MW'(in_data_i.window_length) - MW'(1);
  assign win_end = MW'(idx_q) + MW'(len_q);

  assign cfg_ready_o = 1'b1;
  assign total_o     = total_q;
  assign best_sum_o  = res_sum_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    invalid_d    = invalid_q;
    total_d      = total_q;
    pc_d         = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : pc_q;
    idx_d        = idx_q;
    len_d        = len_q;
    res_idx_d    = res_idx_q;
    res_sum_d    = res_sum_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    wr_o         = '0;
    rd_hi_addr_o = idx_q;
    rd_lo_addr_o = idx_q;
    cmp_ctl_o    = '0;

    unique case (state_q)
      dds_pkg::S_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          out_d       = '{status: dds_pkg::ST_OK, bin_index: '0, window_sum: '0};
          unique case (in_data_i.op)
            dds_pkg::OP_LOAD: begin
              if (in_data_i.first) begin
                count_d   = '0;
                invalid_d = 1'b0;
              end
              if (full) begin
                out_d.status = dds_pkg::ST_FULL;
              end else if (in_data_i.weight[WW-1]) begin
                invalid_d    = 1'b1;
                out_d.status = dds_pkg::ST_NEG;
              end else begin
                wr_o.en         = 1'b1;
                wr_o.addr       = count_eff[AW-1:0];
                wr_o.data       = load_val;
                total_d         = load_val;
                count_d         = count_eff + NW'(1);
                out_d.bin_index = BW'(count_eff);
              end
            end
            dds_pkg::OP_SAMPLE: begin
              if (count_q == '0) begin
                out_d.status = dds_pkg::ST_EMPTY;
              end else if (invalid_q) begin
                out_d.status = dds_pkg::ST_NEG;
              end else begin
                out_valid_d        = out_valid_q && out_stall_i;
                out_d              = out_q;
                cmp_ctl_o.load_lhs = 1'b1;
                rd_hi_addr_o       = '0;
                idx_d              = '0;
                state_d            = dds_pkg::S_SAMPLE;
              end
            end
            dds_pkg::OP_LOCAL: begin
              if (count_q == '0) begin
                out_d.status = dds_pkg::ST_EMPTY;
              end else if (invalid_q) begin
                out_d.status = dds_pkg::ST_NEG;
              end else if (win_bad) begin
                out_d.status = dds_pkg::ST_WIN;
              end else begin
                out_valid_d  = out_valid_q && out_stall_i;
                out_d        = out_q;
                rd_hi_addr_o = len_m1[AW-1:0];
                rd_lo_addr_o = '0;
                idx_d        = '0;
                len_d        = in_data_i.window_length;
                res_idx_d    = '0;
                res_sum_d    = '0;
                state_d      = dds_pkg::S_LOCAL;
              end
            end
            dds_pkg::OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end

      dds_pkg::S_SAMPLE: begin
        if (eval_i.hit || (idx_q == cnt_m1[AW-1:0])) begin
          res_idx_d = idx_q;
          res_sum_d = '0;
          state_d   = dds_pkg::S_FLUSH;
        end else begin
          idx_d        = idx_q + AW'(1);
          rd_hi_addr_o = idx_q + AW'(1);
        end
      end

      dds_pkg::S_LOCAL: begin
        cmp_ctl_o.lo_zero = (idx_q == '0);
        if (eval_i.better) begin
          res_sum_d = eval_i.win_sum;
          res_idx_d = idx_q;
        end
        if (win_end == MW'(count_q)) begin
          state_d = dds_pkg::S_FLUSH;
        end else begin
          idx_d        = idx_q + AW'(1);
          rd_hi_addr_o = win_end[AW-1:0];
          rd_lo_addr_o = idx_q;
        end
      end

      dds_pkg::S_FLUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{status: dds_pkg::ST_OK, bin_index: BW'(res_idx_q),
                          window_sum: res_sum_q};
          state_d     = dds_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = dds_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ src/discrete_distribution_sampler.sv @@
// Top level of the discrete distribution sampler (inverse-CDF over a cumulative table).
// Depends on dds_pkg, dds_ram, dds_cmp and dds_ctrl.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake          Beat contents
//  in        input      in_valid/in_stall  dds_pkg::in_beat_t (op, weight, first, draw, window)
//  out       output     out_valid/stall    dds_pkg::out_beat_t (status, bin, window sum)
//  cfg       input      cfg_valid/ready    8-bit pseudocount
//
//  Loads, no-op beats and every error answer go straight to the output register: the result
//  sits there from the cycle after the input beat is accepted.
//  A sample scans up from bin 0 to the returned bin; a localize slides a window of length L
//  over N loaded bins. Both read one table entry per cycle, then wait for a free output.
//  Reset clears the bin count, the invalid flag and the pseudocount; the table itself
//  is not cleared, since only entries below the bin count are ever read.
//  A finished result waits in the output register under out_stall_i; a new input beat is
//  taken as soon as the block is idle and the output register is free or draining.

module discrete_distribution_sampler (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  dds_pkg::in_beat_t        in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output dds_pkg::out_beat_t       out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [dds_pkg::PC_W-1:0] cfg_data_i
);

  dds_pkg::ram_wr_t             wr;
  logic [dds_pkg::ADDR_W-1:0]   rd_hi_addr;
  logic [dds_pkg::ADDR_W-1:0]   rd_lo_addr;
  logic [dds_pkg::CUM_W-1:0]    rd_hi;
  logic [dds_pkg::CUM_W-1:0]    rd_lo;
  dds_pkg::cmp_ctl_t            cmp_ctl;
  logic [dds_pkg::CUM_W-1:0]    total;
  logic [dds_pkg::CUM_W-1:0]    best_sum;
  dds_pkg::eval_t               eval;

  // The sequencer owns the bookkeeping and walks the table one entry per cycle.
  dds_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .wr_o         (wr),
    .rd_hi_addr_o (rd_hi_addr),
    .rd_lo_addr_o (rd_lo_addr),
    .cmp_ctl_o    (cmp_ctl),
    .total_o      (total),
    .best_sum_o   (best_sum),
    .eval_i       (eval)
  );

  // Two identical copies of the cumulative table, written together. A window sum
  // needs its upper and lower cumulative entries in the same cycle, so each copy
  // serves one of the two read addresses.
  dds_ram #(
    .WIDTH (dds_pkg::CUM_W),
    .DEPTH (dds_pkg::MAX_BINS)
  ) u_ram_hi (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (rd_hi_addr),
    .rdata_o (rd_hi)
  );

  dds_ram #(
    .WIDTH (dds_pkg::CUM_W),
    .DEPTH (dds_pkg::MAX_BINS)
  ) u_ram_lo (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (rd_lo_addr),
    .rdata_o (rd_lo)
  );

  // The scaled draw is registered once at accept; the scan then only compares.
  dds_cmp u_cmp (
    .clk_i      (clk_i),
    .ctl_i      (cmp_ctl),
    .random_i   (in_data_i.random_value),
    .total_i    (total),
    .rd_hi_i    (rd_hi),
    .rd_lo_i    (rd_lo),
    .best_sum_i (best_sum),
    .eval_o     (eval)
  );

endmodule

@@ src/dds_checker.sv @@
// Port-level checks for the discrete distribution sampler, bound to its top level.
// Depends on dds_pkg and discrete_distribution_sampler.
`timescale 1ns / 1ps

module dds_props (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input dds_pkg::in_beat_t        in_data_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input dds_pkg::out_beat_t       out_data_o,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_o,
  input logic [dds_pkg::PC_W-1:0] cfg_data_i
);

  // An error answer carries no bin and no sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != dds_pkg::ST_OK) |->
      (out_data_o.bin_index == '0) && (out_data_o.window_sum == '0))
    else $error("error beat carries nonzero fields");

  // A stalled output beat stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // A no-op beat answers OK with zero fields in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.op == dds_pkg::OP_NONE) |=>
      out_valid_o && (out_data_o.status == dds_pkg::ST_OK) &&
      (out_data_o.bin_index == '0) && (out_data_o.window_sum == '0))
    else $error("no-op beat answered wrongly");

  // A negative weight is refused at once, unless the table is already full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.op == dds_pkg::OP_LOAD) &&
      in_data_i.weight[dds_pkg::WEIGHT_W-1] |=>
      out_valid_o && ((out_data_o.status == dds_pkg::ST_NEG) ||
                      (out_data_o.status == dds_pkg::ST_FULL)))
    else $error("negative weight not refused");

endmodule

bind discrete_distribution_sampler dds_props u_dds_props (.*);
